@@ rtl/core/scgpio_pkg.sv @@
package scgpio_pkg;

    // default line buffer depth and output count
    localparam int unsigned LINE_DEPTH_DEF = 32;
    localparam int unsigned GPIO_COUNT     = 20;

    // characters of interest
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_2  = 8'h32;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_H  = 8'h48;

    // response codes
    typedef enum logic [2:0] {
        RESP_NONE = 3'd0,
        RESP_OK   = 3'd1,
        RESP_NG   = 3'd2,
        RESP_OVF  = 3'd3,
        RESP_HELP = 3'd4
    } resp_t;

    // command words, right aligned, first character in the highest used byte
    localparam int unsigned STR_BITS = 88;
    localparam logic [STR_BITS-1:0] STR_CMD     = STR_BITS'("cmd");
    localparam logic [STR_BITS-1:0] STR_HELP    = STR_BITS'("help");
    localparam logic [STR_BITS-1:0] STR_QUERY   = STR_BITS'("?");
    localparam logic [STR_BITS-1:0] STR_RELAYAO = STR_BITS'("relayALLoff");
    localparam logic [STR_BITS-1:0] STR_GPIOALL = STR_BITS'("GPIOALLL");
    localparam logic [STR_BITS-1:0] STR_GPIOALH = STR_BITS'("GPIOALLH");
    localparam logic [STR_BITS-1:0] STR_RELAY   = STR_BITS'("relay");
    localparam logic [STR_BITS-1:0] STR_GPIO    = STR_BITS'("GPIO");

    localparam logic [3:0] LEN_CMD     = 4'd3;
    localparam logic [3:0] LEN_HELP    = 4'd4;
    localparam logic [3:0] LEN_QUERY   = 4'd1;
    localparam logic [3:0] LEN_RELAYAO = 4'd11;
    localparam logic [3:0] LEN_GPIOALL = 4'd8;
    localparam logic [3:0] LEN_RELAY   = 4'd5;
    localparam logic [3:0] LEN_GPIO    = 4'd4;

    // true when character c equals the word's character at position pos
    function automatic logic cmd_char_eq(input logic [7:0] c,
                                         input logic [STR_BITS-1:0] s,
                                         input logic [3:0] slen,
                                         input logic [3:0] pos);
        logic [3:0] idx;
        logic [6:0] bitpos;
        idx    = slen - pos - 4'd1;
        bitpos = {idx, 3'b000};
        if (pos >= slen)
        begin
            return 1'b0;
        end
        return c == s[bitpos +: 8];
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic  capture;
        logic  cnt_clear;
        logic  cnt_inc;
        logic  buf_write;
        logic  scan_start;
        logic  scan_run;
        logic  exec;
        logic  out_load;
        resp_t resp;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic line_full;
        logic lead_lf;
        logic is_cr;
        logic scan_done;
    } dp_status_t;

endpackage

@@ rtl/core/scgpio_ram.sv @@
module scgpio_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/scgpio_dp.sv @@
module scgpio_dp
    import scgpio_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [7:0]            rx_byte,
    output logic [7:0]            echo_byte,
    output logic [2:0]            response,
    output logic [3:0]            relay_address,
    output logic [GPIO_COUNT-1:0] gpio_levels
);

    localparam int unsigned AW = $clog2(LINE_DEPTH);

    // control state
    logic [AW-1:0]         char_count_reg, char_count_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                  cmp_valid_reg;
    logic [3:0]            mux_reg, mux_next;
    logic [GPIO_COUNT-1:0] gpio_reg, gpio_next;

    // payload state
    logic [AW-1:0]         len_reg;
    logic [AW-1:0]         cmp_pos_reg;
    logic [7:0]            echo_reg;
    resp_t                 resp_reg, exec_resp;
    logic                  m_cmd_reg, m_help_reg, m_query_reg;
    logic                  m_alloff_reg, m_alll_reg, m_allh_reg;
    logic                  p_relay_reg, p_gpio_reg;
    logic [7:0]            d4_reg, d5_reg, d6_reg;
    logic [7:0]            echo_out_reg;
    resp_t                 resp_out_reg;
    logic [3:0]            relay_out_reg;
    logic [GPIO_COUNT-1:0] gpio_out_reg;

    logic                  rd_issue;
    logic [7:0]            rd_data;
    logic [3:0]            pos4;

    // line buffer
    scgpio_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (cmd.buf_write),
        .wr_addr (char_count_reg),
        .wr_data (rx_byte),
        .rd_en   (rd_issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // status toward the controller
    assign status.line_full = char_count_reg == AW'(LINE_DEPTH - 1);
    assign status.lead_lf   = (char_count_reg == '0) && (rx_byte == CH_LF);
    assign status.is_cr     = rx_byte == CH_CR;
    assign status.scan_done = (rd_ptr_reg == len_reg) && !cmp_valid_reg;

    assign rd_issue = cmd.scan_run && (rd_ptr_reg != len_reg);
    assign pos4     = cmp_pos_reg[3:0];

    // character count
    always_comb
    begin
        char_count_next = char_count_reg;
        if (cmd.cnt_clear)
        begin
            char_count_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            char_count_next = char_count_reg + AW'(1);
        end
    end

    // scan read pointer
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (cmd.scan_start)
        begin
            rd_ptr_next = '0;
        end
        else if (rd_issue)
        begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
    end

    // number decode for relay and gpio lines
    logic       len6, len7;
    logic [3:0] relay_n;
    logic       relay_ok;
    logic [3:0] relay_addr;
    logic [7:0] g_last;
    logic       g_num_ok;
    logic [4:0] g_n;
    logic [4:0] g_idx;
    logic       g_ok;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    always_comb
    begin
        len6 = len_reg == AW'(6);
        len7 = len_reg == AW'(7);

        relay_n  = len6 ? d5_reg[3:0] : 4'd10;
        relay_ok = p_relay_reg &&
                   ((len6 && d5_reg >= CH_1 && d5_reg <= CH_9) ||
                    (len7 && d5_reg == CH_1 && d6_reg == CH_0));
        relay_addr = (relay_n < 4'd7) ? relay_n : relay_n + 4'd1;

        g_last   = len6 ? d5_reg : d6_reg;
        g_num_ok = len6 ? (d4_reg >= CH_1 && d4_reg <= CH_9)
                        : ((d4_reg == CH_1 && is_digit(d5_reg)) ||
                           (d4_reg == CH_2 && d5_reg == CH_0));
        if (len6)
        begin
            g_n = {1'b0, d4_reg[3:0]};
        end
        else if (d4_reg == CH_1)
        begin
            g_n = 5'd10 + {1'b0, d5_reg[3:0]};
        end
        else
        begin
            g_n = 5'd20;
        end
        g_idx = g_n - 5'd1;
        g_ok  = p_gpio_reg && (len6 || len7) && g_num_ok &&
                (g_last == CH_L || g_last == CH_H);
    end

    // command execution at the end of a line
    always_comb
    begin
        mux_next  = mux_reg;
        gpio_next = gpio_reg;
        exec_resp = RESP_NG;
        priority if (m_cmd_reg || m_help_reg || m_query_reg)
        begin
            exec_resp = RESP_HELP;
        end
        else if (m_alloff_reg)
        begin
            mux_next  = 4'd0;
            exec_resp = RESP_OK;
        end
        else if (m_alll_reg)
        begin
            gpio_next = '0;
            exec_resp = RESP_OK;
        end
        else if (m_allh_reg)
        begin
            gpio_next = '1;
            exec_resp = RESP_OK;
        end
        else if (p_relay_reg && (len6 || len7))
        begin
            if (relay_ok)
            begin
                mux_next  = relay_addr;
                exec_resp = RESP_OK;
            end
        end
        else if (g_ok)
        begin
            if (g_last == CH_H)
            begin
                gpio_next = gpio_reg | (GPIO_COUNT'(1) << g_idx);
            end
            else
            begin
                gpio_next = gpio_reg & ~(GPIO_COUNT'(1) << g_idx);
            end
            exec_resp = RESP_OK;
        end
        if (!cmd.exec)
        begin
            mux_next  = mux_reg;
            gpio_next = gpio_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg <= '0;
            rd_ptr_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            mux_reg        <= '0;
            gpio_reg       <= '0;
        end
        else
        begin
            char_count_reg <= char_count_next;
            rd_ptr_reg     <= rd_ptr_next;
            cmp_valid_reg  <= rd_issue;
            mux_reg        <= mux_next;
            gpio_reg       <= gpio_next;
        end
    end

    // payload registers: capture, match flags, output stage
    always_ff @(posedge clk)
    begin
        cmp_pos_reg <= rd_ptr_reg;
        if (cmd.capture)
        begin
            echo_reg <= rx_byte;
            resp_reg <= cmd.resp;
        end
        if (cmd.exec)
        begin
            resp_reg <= exec_resp;
        end
        if (cmd.scan_start)
        begin
            len_reg      <= char_count_reg;
            m_cmd_reg    <= char_count_reg == AW'(LEN_CMD);
            m_help_reg   <= char_count_reg == AW'(LEN_HELP);
            m_query_reg  <= char_count_reg == AW'(LEN_QUERY);
            m_alloff_reg <= char_count_reg == AW'(LEN_RELAYAO);
            m_alll_reg   <= char_count_reg == AW'(LEN_GPIOALL);
            m_allh_reg   <= char_count_reg == AW'(LEN_GPIOALL);
            p_relay_reg  <= 1'b1;
            p_gpio_reg   <= 1'b1;
        end
        else if (cmp_valid_reg)
        begin
            m_cmd_reg    <= m_cmd_reg    && cmd_char_eq(rd_data, STR_CMD, LEN_CMD, pos4);
            m_help_reg   <= m_help_reg   && cmd_char_eq(rd_data, STR_HELP, LEN_HELP, pos4);
            m_query_reg  <= m_query_reg  && cmd_char_eq(rd_data, STR_QUERY, LEN_QUERY, pos4);
            m_alloff_reg <= m_alloff_reg &&
                            cmd_char_eq(rd_data, STR_RELAYAO, LEN_RELAYAO, pos4);
            m_alll_reg   <= m_alll_reg   &&
                            cmd_char_eq(rd_data, STR_GPIOALL, LEN_GPIOALL, pos4);
            m_allh_reg   <= m_allh_reg   &&
                            cmd_char_eq(rd_data, STR_GPIOALH, LEN_GPIOALL, pos4);
            p_relay_reg  <= p_relay_reg && ((cmp_pos_reg >= AW'(LEN_RELAY)) ||
                            cmd_char_eq(rd_data, STR_RELAY, LEN_RELAY, pos4));
            p_gpio_reg   <= p_gpio_reg && ((cmp_pos_reg >= AW'(LEN_GPIO)) ||
                            cmd_char_eq(rd_data, STR_GPIO, LEN_GPIO, pos4));
            if (cmp_pos_reg == AW'(4))
            begin
                d4_reg <= rd_data;
            end
            if (cmp_pos_reg == AW'(5))
            begin
                d5_reg <= rd_data;
            end
            if (cmp_pos_reg == AW'(6))
            begin
                d6_reg <= rd_data;
            end
        end
        if (cmd.out_load)
        begin
            echo_out_reg  <= echo_reg;
            resp_out_reg  <= resp_reg;
            relay_out_reg <= mux_reg;
            gpio_out_reg  <= gpio_reg;
        end
    end

    assign echo_byte     = echo_out_reg;
    assign response      = resp_out_reg;
    assign relay_address = relay_out_reg;
    assign gpio_levels   = gpio_out_reg;

endmodule

@@ rtl/core/scgpio_ctrl.sv @@
module scgpio_ctrl
    import scgpio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    output logic       res_valid,
    input  logic       res_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;

    assign rx_stall  = state_reg != ST_IDLE;
    assign res_valid = res_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.resp   = RESP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.capture = 1'b1;
                    priority if (status.line_full)
                    begin
                        cmd.cnt_clear = 1'b1;
                        cmd.resp      = RESP_OVF;
                        state_next    = ST_DONE;
                    end
                    else if (status.lead_lf)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (status.is_cr)
                    begin
                        cmd.cnt_clear  = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.buf_write = 1'b1;
                        cmd.cnt_inc   = 1'b1;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ rtl/core/serial_command_line_to_gpio_unit.sv @@
// a byte that does not end a line is captured and its result loaded into the output
// registers from the DONE state; a CR ending a line first walks the line buffer's read port
// one byte per cycle in the SCAN state, then executes in the EXEC state before DONE
// the unit takes no new byte until the result of the last one has been loaded
// reset: asynchronous, active low; clears the line count, relay and GPIO state and result valid
module serial_command_line_to_gpio_unit
    import scgpio_pkg::*;
#(
    parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_stall,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [7:0]            echo_byte,
    output logic [2:0]            response,
    output logic [3:0]            relay_address,
    output logic [GPIO_COUNT-1:0] gpio_levels
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    scgpio_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // line buffer, matcher and output registers
    scgpio_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx_byte),
        .echo_byte     (echo_byte),
        .response      (response),
        .relay_address (relay_address),
        .gpio_levels   (gpio_levels)
    );

    // relay address skips 7 and never exceeds 11
    a_relay_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (relay_address != 4'd7) && (relay_address < 4'd12))
        else $error("relay address out of range");

    // only a CR may carry ok, not recognized or help
    a_resp_on_cr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (response == RESP_OK || response == RESP_NG ||
                      response == RESP_HELP) |-> echo_byte == CH_CR)
        else $error("command response on a byte other than CR");

    // a CR always produces a response
    a_cr_resp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (echo_byte == CH_CR) |-> response != RESP_NONE)
        else $error("CR without response");

    // one byte in flight: stall follows every input transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && !rx_stall |=> rx_stall)
        else $error("second byte taken while one is in flight");

endmodule
